>>> design/tsm_pkg.sv
// package for the typed stack machine: cell kinds, opcodes, status codes
// no dependencies
package tsm_pkg;

  localparam int unsigned StackDepth = 63;
  localparam int unsigned SpW = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    KIND_ERR  = 2'd0,
    KIND_NUM  = 2'd1,
    KIND_BOOL = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_TYPE      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_PUSH  = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_POP   = 4'd6,
    OP_DUP   = 4'd7,
    OP_INC   = 4'd8,
    OP_DEC   = 4'd9,
    OP_TRUE  = 4'd10,
    OP_FALSE = 4'd11,
    OP_EQ    = 4'd12,
    OP_NOT   = 4'd13,
    OP_AND   = 4'd14,
    OP_OR    = 4'd15
  } opcode_e;

  localparam logic [31:0] ErrUnderflow = 32'd2;
  localparam logic [31:0] ErrType = 32'd3;

  // decoded instruction handed from front to back
  typedef struct packed {
    opcode_e     op;
    logic [31:0] value;
    logic [1:0]  n_pops;
    logic        pushes;
  } instr_t;

endpackage

>>> design/typed_stack_machine_top.sv
// top level of the typed stack machine: stream ports, front end, back end
// depends on tsm_pkg, tsm_front, tsm_back (and tsm_divider below it)
//
//  channel | dir | tdata fields (low bit first)       | tuser
//  s_axis  | in  | opcode[3:0], push_value[35:4]      | none
//  m_axis  | out | status[1:0], top_kind[3:2],        | none
//          |     | top_value[35:4], depth[41:36]      |
//
// steps, from the back end taking a queued beat to the result: take, read top,
//   read second (two-operand only), execute, re-read top, load result; mul adds a
//   registered 32x32 product step and div waits on the 48-step bit-serial
//   divider until it signals done
// the front queue holds two beats, so input is taken while the back end works
// reset clears the stack pointer and control state; stack ram holds no reset value
// a result waits in the output register until taken; the back end stalls then

module typed_stack_machine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // opcode, push_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status, top_kind, top_value, depth
);

  logic            q_valid, q_ready;
  tsm_pkg::instr_t q_instr;
  logic [1:0]      status, top_kind;
  logic [31:0]     top_value;
  logic [5:0]      depth;

  // front: decode and queue
  tsm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .opcode_i    (s_axis_tdata[3:0]),
    .push_value_i(s_axis_tdata[35:4]),
    .q_valid_o   (q_valid),
    .q_ready_i   (q_ready),
    .q_instr_o   (q_instr)
  );

  // back: stack and execute
  tsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_instr_i   (q_instr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .top_kind_o  (top_kind),
    .top_value_o (top_value),
    .depth_o     (depth)
  );

  assign m_axis_tdata = {6'd0, depth, top_value, top_kind, status};

  // an overflow report always comes with depth at the stack limit
  property p_ovf_full;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && status == tsm_pkg::ST_OVERFLOW) |->
        (depth == 6'(tsm_pkg::StackDepth));
  endproperty
  a_ovf_full: assert property (p_ovf_full) else $error("overflow without full stack");

  // an error top cell never shows with a status of none
  property p_err_status;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && top_kind == tsm_pkg::KIND_ERR) |-> (status != tsm_pkg::ST_NONE);
  endproperty
  a_err_status: assert property (p_err_status) else $error("error cell with clean status");

  // empty stack shows the underflow cell
  property p_empty;
    @(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && depth == 6'd0) |-> (top_kind == tsm_pkg::KIND_ERR);
  endproperty
  a_empty: assert property (p_empty) else $error("empty stack without underflow cell");

endmodule

>>> design/tsm_front.sv
// front end: accepts instructions, classifies them, queues them for the back end
// depends on tsm_pkg
module tsm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [3:0]       opcode_i,
  input  logic [31:0]      push_value_i,
  output logic             q_valid_o,
  input  logic             q_ready_i,
  output tsm_pkg::instr_t  q_instr_o
);

  localparam int unsigned PtrW = $clog2(tsm_pkg::QueueDepth);

  tsm_pkg::instr_t          mem_q [tsm_pkg::QueueDepth];
  logic [PtrW-1:0]          wr_q, rd_q;
  logic [PtrW:0]            cnt_q;
  tsm_pkg::instr_t          dec;
  logic                     push_en, pop_en;

  always_comb begin
    dec.op = tsm_pkg::opcode_e'(opcode_i);
    dec.value = push_value_i;
    dec.n_pops = 2'd0;
    dec.pushes = 1'b0;
    unique case (dec.op)
      tsm_pkg::OP_PUSH, tsm_pkg::OP_DUP, tsm_pkg::OP_TRUE, tsm_pkg::OP_FALSE: begin
        dec.pushes = 1'b1;
      end
      tsm_pkg::OP_POP, tsm_pkg::OP_INC, tsm_pkg::OP_DEC, tsm_pkg::OP_NOT: begin
        dec.n_pops = 2'd1;
      end
      tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL, tsm_pkg::OP_DIV,
      tsm_pkg::OP_EQ, tsm_pkg::OP_AND, tsm_pkg::OP_OR: begin
        dec.n_pops = 2'd2;
      end
      default: ;
    endcase
  end

  assign in_ready_o = (cnt_q != (PtrW+1)'(tsm_pkg::QueueDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_instr_o  = mem_q[rd_q];
  assign push_en    = in_valid_i && in_ready_o;
  assign pop_en     = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem_q[wr_q] <= dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push_en) wr_q <= wr_q + 1'b1;
      if (pop_en) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_en) - (PtrW+1)'(pop_en);
    end
  end

endmodule

>>> design/tsm_divider.sv
// bit-serial unsigned divider, one quotient bit per cycle
// no dependencies (uses nothing from tsm_pkg, kept standalone)
module tsm_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [47:0] quotient_o
);

  logic [47:0] quo_q;
  logic [32:0] rem_q;
  logic [31:0] dvs_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [32:0] trial;
  logic [32:0] shifted;

  assign shifted = {rem_q[31:0], quo_q[47]};
  assign trial = shifted - {1'b0, dvs_q};
  assign quotient_o = quo_q;
  assign done_o = busy_q && (cnt_q == 6'd0);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q && cnt_q != 6'd0) begin
      if (!trial[32]) begin
        rem_q <= trial;
        quo_q <= {quo_q[46:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[46:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 6'd48;
    end else if (busy_q) begin
      if (cnt_q == 6'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 6'd1;
    end
  end

endmodule

>>> design/tsm_back.sv
// back end: stack memory, operand fetch, execute, result register
// depends on tsm_pkg and tsm_divider
module tsm_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  output logic             q_ready_o,
  input  tsm_pkg::instr_t  q_instr_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       status_o,
  output logic [1:0]       top_kind_o,
  output logic [31:0]      top_value_o,
  output logic [5:0]       depth_o
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_RD_B  = 8'b00000010,
    S_RD_A  = 8'b00000100,
    S_EXEC  = 8'b00001000,
    S_MUL   = 8'b00010000,
    S_DIV   = 8'b00100000,
    S_RD_T  = 8'b01000000,
    S_TOP   = 8'b10000000
  } state_e;

  localparam int unsigned SpW = tsm_pkg::SpW;
  localparam int unsigned AddrW = tsm_pkg::AddrW;
  localparam logic [SpW-1:0] Full = SpW'(tsm_pkg::StackDepth);

  state_e          state_q, state_d;
  logic [33:0]     mem_q [tsm_pkg::StackDepth];
  logic [33:0]     rd_data_q;
  logic [SpW-1:0]  sp_q;
  tsm_pkg::instr_t ins_q;
  logic [1:0]      kb_q, ka_q;
  logic [31:0]     vb_q, va_q;
  logic            dropped_q;
  logic            out_valid_q;
  logic [1:0]      status_q, kind_q;
  logic [31:0]     value_q;
  logic [5:0]      depth_q;
  logic [63:0]     prod_q;
  logic            rd_present_q;
  logic [33:0]     fetched;

  // memory port control
  logic            mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [33:0]     mem_wd;

  logic            div_start, div_done;
  logic [47:0]     div_quo;
  logic [31:0]     mag_a, mag_b;
  logic [31:0]     mag_a_fetch;

  // dividend comes straight from the fetch of the second operand
  tsm_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({mag_a_fetch, 16'd0}),
    .divisor_i (mag_b),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign mag_a = va_q[31] ? (~va_q + 32'd1) : va_q;
  assign mag_b = vb_q[31] ? (~vb_q + 32'd1) : vb_q;
  assign mag_a_fetch = fetched[31] ? (~fetched[31:0] + 32'd1) : fetched[31:0];

  function automatic logic [31:0] sat33(input logic [32:0] x);
    if (x[32] != x[31]) return x[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    return x[31:0];
  endfunction

  // saturating signed magnitude result
  function automatic logic [31:0] sat_mag(input logic [47:0] m, input logic neg);
    if (neg) begin
      if (m > 48'h8000_0000) return 32'h8000_0000;
      return ~m[31:0] + 32'd1;
    end
    if (m > 48'h7fff_ffff) return 32'h7fff_ffff;
    return m[31:0];
  endfunction

  // the operand fetch: the cell at sp-k, underflow cell when absent
  logic [SpW-1:0] rd_idx;
  logic           rd_present;

  // execute result
  logic           do_push;
  logic [33:0]    push_cell;
  logic [SpW-1:0] sp_after_pop;

  assign q_ready_o = (state_q == S_IDLE) && !out_valid_q;

  always_comb begin
    sp_after_pop = sp_q;
    if (ins_q.n_pops == 2'd1) begin
      sp_after_pop = (sp_q == '0) ? '0 : sp_q - SpW'(1);
    end else if (ins_q.n_pops == 2'd2) begin
      sp_after_pop = (sp_q < SpW'(2)) ? '0 : sp_q - SpW'(2);
    end
  end

  always_comb begin
    do_push = 1'b0;
    push_cell = {tsm_pkg::KIND_ERR, tsm_pkg::ErrType};
    case (ins_q.op)
      tsm_pkg::OP_PUSH: begin
        do_push = 1'b1;
        push_cell = {tsm_pkg::KIND_NUM, ins_q.value};
      end
      tsm_pkg::OP_DUP: begin
        do_push = 1'b1;
        push_cell = {kb_q, vb_q};
      end
      tsm_pkg::OP_TRUE: begin
        do_push = 1'b1;
        push_cell = {tsm_pkg::KIND_BOOL, 32'd1};
      end
      tsm_pkg::OP_FALSE: begin
        do_push = 1'b1;
        push_cell = {tsm_pkg::KIND_BOOL, 32'd0};
      end
      tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL, tsm_pkg::OP_DIV: begin
        if (ka_q == tsm_pkg::KIND_NUM && kb_q == tsm_pkg::KIND_NUM) begin
          do_push = 1'b1;
          if (ins_q.op == tsm_pkg::OP_ADD)
            push_cell = {tsm_pkg::KIND_NUM,
                         sat33({va_q[31], va_q} + {vb_q[31], vb_q})};
          else if (ins_q.op == tsm_pkg::OP_SUB)
            push_cell = {tsm_pkg::KIND_NUM,
                         sat33({va_q[31], va_q} - {vb_q[31], vb_q})};
          else if (ins_q.op == tsm_pkg::OP_MUL)
            push_cell = {tsm_pkg::KIND_NUM,
                         sat_mag(prod_q[63:16], va_q[31] ^ vb_q[31])};
          else if (vb_q == 32'd0)
            push_cell = {tsm_pkg::KIND_NUM, va_q[31] ? 32'h8000_0000 :
                         (va_q == 32'd0 ? 32'd0 : 32'h7fff_ffff)};
          else
            push_cell = {tsm_pkg::KIND_NUM, sat_mag(div_quo, va_q[31] ^ vb_q[31])};
        end else if (kb_q != tsm_pkg::KIND_ERR) begin
          do_push = 1'b1;
        end
      end
      tsm_pkg::OP_INC, tsm_pkg::OP_DEC: begin
        if (kb_q == tsm_pkg::KIND_NUM) begin
          do_push = 1'b1;
          push_cell = {tsm_pkg::KIND_NUM, sat33({vb_q[31], vb_q} +
                       ((ins_q.op == tsm_pkg::OP_INC) ? 33'h0_0001_0000 : 33'h1_ffff_0000))};
        end else if (kb_q != tsm_pkg::KIND_ERR) begin
          do_push = 1'b1;
        end
      end
      tsm_pkg::OP_NOT: begin
        if (kb_q == tsm_pkg::KIND_BOOL) begin
          do_push = 1'b1;
          push_cell = {tsm_pkg::KIND_BOOL, (vb_q == 32'd0) ? 32'd1 : 32'd0};
        end else if (kb_q != tsm_pkg::KIND_ERR) begin
          do_push = 1'b1;
        end
      end
      tsm_pkg::OP_AND, tsm_pkg::OP_OR: begin
        if (ka_q == tsm_pkg::KIND_BOOL && kb_q == tsm_pkg::KIND_BOOL) begin
          do_push = 1'b1;
          push_cell = {tsm_pkg::KIND_BOOL, 31'd0,
                       (ins_q.op == tsm_pkg::OP_AND) ? (|va_q && |vb_q) : (|va_q || |vb_q)};
        end else if (kb_q != tsm_pkg::KIND_ERR) begin
          do_push = 1'b1;
        end
      end
      tsm_pkg::OP_EQ: begin
        if (ka_q != tsm_pkg::KIND_ERR && kb_q != tsm_pkg::KIND_ERR) begin
          do_push = 1'b1;
          push_cell = {tsm_pkg::KIND_BOOL, 31'd0, (ka_q == kb_q) && (va_q == vb_q)};
        end
      end
      default: ;
    endcase
  end

  // next state, memory write, divider start and read index selection per state
  always_comb begin
    rd_idx = '0;
    rd_present = 1'b0;
    state_d = state_q;
    div_start = 1'b0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = push_cell;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && !out_valid_q) state_d = S_RD_B;
      end
      S_RD_B: begin
        state_d = (ins_q.n_pops == 2'd2) ? S_RD_A : S_EXEC;
      end
      S_RD_A: begin
        if (ins_q.op == tsm_pkg::OP_MUL) state_d = S_MUL;
        else if (ins_q.op == tsm_pkg::OP_DIV) state_d = S_DIV;
        else state_d = S_EXEC;
      end
      S_MUL: state_d = S_EXEC;
      S_DIV: begin
        if (div_done) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (do_push && sp_after_pop != Full) begin
          mem_we = 1'b1;
          mem_wa = sp_after_pop[AddrW-1:0];
        end
        state_d = S_RD_T;
      end
      // new top is read here, after the write and pointer update
      S_RD_T: state_d = S_TOP;
      S_TOP: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    // address for next registered read
    if (state_q == S_IDLE) begin
      rd_idx = sp_q - SpW'(1);
      rd_present = (sp_q != '0);
    end else if (state_q == S_RD_B) begin
      rd_idx = sp_q - SpW'(2);
      rd_present = (sp_q > SpW'(1));
    end else begin
      rd_idx = sp_q - SpW'(1);
      rd_present = (sp_q != '0);
    end
    if (state_q == S_RD_A && ins_q.op == tsm_pkg::OP_DIV) div_start = 1'b1;
  end

  assign mem_ra = rd_idx[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_data_q <= mem_q[mem_ra];
  end

  assign fetched = rd_present_q ? rd_data_q : {tsm_pkg::KIND_ERR, tsm_pkg::ErrUnderflow};

  always_ff @(posedge clk_i) begin
    rd_present_q <= rd_present;
    if (state_q == S_IDLE && q_valid_i && !out_valid_q) ins_q <= q_instr_i;
    if (state_q == S_RD_B) begin
      kb_q <= fetched[33:32];
      vb_q <= fetched[31:0];
    end
    if (state_q == S_RD_A) begin
      ka_q <= fetched[33:32];
      va_q <= fetched[31:0];
    end
    if (state_q == S_MUL) prod_q <= 64'(mag_a) * 64'(mag_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q <= '0;
      dropped_q <= 1'b0;
      out_valid_q <= 1'b0;
      status_q <= '0;
      kind_q <= '0;
      value_q <= '0;
      depth_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_EXEC) begin
        if (do_push && sp_after_pop == Full) begin
          dropped_q <= 1'b1;
          sp_q <= sp_after_pop;
        end else begin
          dropped_q <= 1'b0;
          sp_q <= sp_after_pop + SpW'(do_push);
        end
      end
      if (state_q == S_TOP) begin
        out_valid_q <= 1'b1;
        kind_q <= fetched[33:32];
        value_q <= fetched[31:0];
        depth_q <= 6'(sp_q);
        if (dropped_q) status_q <= tsm_pkg::ST_OVERFLOW;
        else if (fetched[33:32] == tsm_pkg::KIND_ERR) status_q <= fetched[1:0];
        else status_q <= tsm_pkg::ST_NONE;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o = status_q;
  assign top_kind_o = kind_q;
  assign top_value_o = value_q;
  assign depth_o = depth_q;

endmodule
